>>> rtl/core/spq_pkg.sv
package spq_pkg;

    localparam int KEY_W = 32;
    localparam int OCC_W = 7;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;       // capture input key, start index at the count
        logic rd_prev;    // read the entry just below the index
        logic rd_head;    // read the smallest entry
        logic wr_shift;   // move the entry read last one place up, step down
        logic wr_key;     // write the new key at the index, count up
        logic pop;        // take the entry read last, advance head, count down
        logic set_empty;  // flag dequeue from empty queue
        logic set_drop;   // flag enqueue into full queue
        logic res_load;   // move the finished result into the output register
    } spq_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic empty;
        logic full;
        logic idx_zero;
        logic greater;    // entry read last is above the new key
        logic out_free;   // output register can take a result this cycle
    } spq_sts_t;

endpackage

>>> rtl/core/spq_ctrl.sv
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_kind,
    output logic     in_ready,
    input  spq_sts_t sts,
    output spq_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_CHK  = 6'b000010,
        ST_CMP  = 6'b000100,
        ST_HEAD = 6'b001000,
        ST_POP  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    localparam logic KIND_ENQ = 1'b0;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Sequence one item through insertion or removal
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_kind == KIND_ENQ)
                    begin
                        if (sts.full)
                        begin
                            cmd.set_drop = 1'b1;
                            state_next   = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_CHK;
                        end
                    end
                    else
                    begin
                        if (sts.empty)
                        begin
                            cmd.set_empty = 1'b1;
                            state_next    = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_HEAD;
                        end
                    end
                end
            end
            ST_CHK:
            begin
                if (sts.idx_zero)
                begin
                    cmd.wr_key = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (sts.greater)
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = ST_CHK;
                end
                else
                begin
                    cmd.wr_key = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_HEAD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = ST_POP;
            end
            ST_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Shifting and popping never start while the sequencer is idle
    a_no_work_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !(cmd.wr_shift || cmd.wr_key || cmd.pop))
        else $error("datapath command issued while idle");

    // A compare always follows a read of the lower neighbor
    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> $past(cmd.rd_prev))
        else $error("compare without preceding read");

    // A pop always follows a head read
    a_pop_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> $past(cmd.rd_head))
        else $error("pop without preceding head read");

endmodule

>>> rtl/core/spq_dpath.sv
module spq_dpath
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [KEY_W-1:0] in_key,
    input  spq_cmd_t                 cmd,
    output spq_sts_t                 sts,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [KEY_W-1:0] out_value,
    output logic                     out_empty,
    output logic                     out_drop,
    output logic [OCC_W-1:0]         out_occ
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] mem [CAPACITY];

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] rdata_reg;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           count_reg;
    logic [AW-1:0]           head_reg;

    logic signed [KEY_W-1:0] res_value_reg;
    logic                    res_empty_reg;
    logic                    res_drop_reg;

    logic                    out_valid_reg;
    logic signed [KEY_W-1:0] out_value_reg;
    logic                    out_empty_reg;
    logic                    out_drop_reg;
    logic [OCC_W-1:0]        out_occ_reg;

    logic [CW-1:0] idx_m1;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] prev_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] head_inc;

    // Map a position in the sorted run to a slot of the circular store
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [AW-1:0] ofs);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= (AW+1)'(CAPACITY))
        begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign idx_m1    = idx_reg - 1'b1;
    assign wr_addr   = slot(head_reg, idx_reg[AW-1:0]);
    assign prev_addr = slot(head_reg, idx_m1[AW-1:0]);
    assign rd_addr   = cmd.rd_head ? head_reg : prev_addr;
    assign head_inc  = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;

    assign sts.empty    = (count_reg == '0);
    assign sts.full     = (count_reg == CW'(CAPACITY));
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.greater  = (rdata_reg > key_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    // Key store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_shift)
        begin
            mem[wr_addr] <= rdata_reg;
        end
        else if (cmd.wr_key)
        begin
            mem[wr_addr] <= key_reg;
        end
        if (cmd.rd_prev || cmd.rd_head)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Capture the key, hold the staged result fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg       <= in_key;
            res_value_reg <= '0;
            res_empty_reg <= cmd.set_empty;
            res_drop_reg  <= cmd.set_drop;
        end
        else if (cmd.pop)
        begin
            res_value_reg <= rdata_reg;
        end
        if (cmd.res_load)
        begin
            out_value_reg <= res_value_reg;
            out_empty_reg <= res_empty_reg;
            out_drop_reg  <= res_drop_reg;
            out_occ_reg   <= OCC_W'(count_reg);
        end
    end

    // Track occupancy, head slot and insertion index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            head_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= count_reg;
            end
            else if (cmd.wr_shift)
            begin
                idx_reg <= idx_m1;
            end
            if (cmd.wr_key)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - 1'b1;
                head_reg  <= head_inc;
            end
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_empty = out_empty_reg;
    assign out_drop  = out_drop_reg;
    assign out_occ   = out_occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= AW'(CAPACITY - 1))
        else $error("head slot out of range");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_key |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not raise occupancy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

endmodule

>>> rtl/core/sorted_priority_queue.sv
// Sorted priority queue over a circular key store with one read and one write port.
// Steps: a drop or an empty dequeue goes straight to the result; a dequeue reads the head, then pops
//   it; an enqueue reads, compares and shifts up each larger key below it, then writes the new key.
// Throughput: one item at a time; the read/compare/shift step per larger key sets the enqueue
//   rate. A finished result waits in the output register.
// Reset: queue empty, head at slot 0, no result pending; key store contents are not cleared.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic        s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value, [38:32] occupancy, [39] zero
    output logic [1:0]  m_tuser    // [0] was_empty, [1] dropped
);

    spq_cmd_t                cmd;
    spq_sts_t                sts;
    logic signed [KEY_W-1:0] out_value;
    logic                    out_empty;
    logic                    out_drop;
    logic [OCC_W-1:0]        out_occ;

    spq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_key    (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_value (out_value),
        .out_empty (out_empty),
        .out_drop  (out_drop),
        .out_occ   (out_occ)
    );

    assign m_tdata = {1'b0, out_occ, out_value};
    assign m_tuser = {out_drop, out_empty};

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP = 1'b1;
    localparam int DIRECTED_OPS = 18;
    localparam int RANDOM_OPS = 1030;
    localparam int TAIL_OPS = 120;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AFTER = 150;
    // Slowest enqueue shifts past every held key, plus some slack
    localparam int DRAIN_CYCLES = 4 + 2 * QUEUE_DEPTH + 20;

    typedef struct {
        logic             kind;
        logic [KEY_W-1:0] key;
        bit               wait_idle;   // hold this op until every result is back
    } pq_op_t;

    typedef struct {
        logic [KEY_W-1:0] value;
        logic             was_empty;
        logic             dropped;
        logic [OCC_W-1:0] occupancy;
    } pq_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [31:0] key
    logic        s_tuser = 1'b0;   // [0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [31:0] value, [38:32] occupancy, [39] zero
    logic [1:0]  m_tuser;          // [0] was_empty, [1] dropped

    // Predictor state: keys in ascending order, oldest first among equals
    logic signed [KEY_W-1:0] held_keys[$];

    pq_op_t     pending_ops[$];
    pq_result_t awaited_results[$];
    pq_op_t     cur_op;
    pq_result_t want_res;
    int         src_gap;
    int         sink_stall;
    int         sent_count;
    int         results_seen;
    int         mismatches;
    int         hold_count;
    bit         hold_used;
    bit         tail_phase;
    int         gen_count;
    bit         pause_next;
    logic       long_hold_active;

    sorted_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Apply one op to the predicted queue and return the result it gives
    function automatic pq_result_t pq_apply_op(pq_op_t op);
        pq_result_t res;
        int         pos;
        res = '{value: '0, was_empty: 1'b0, dropped: 1'b0, occupancy: '0};
        if (op.kind == KIND_PUSH)
        begin
            if (held_keys.size() >= QUEUE_DEPTH)
                res.dropped = 1'b1;
            else
            begin
                pos = 0;
                while (pos < held_keys.size() && held_keys[pos] <= $signed(op.key))
                    pos++;
                held_keys.insert(pos, op.key);
            end
        end
        else if (held_keys.size() == 0)
            res.was_empty = 1'b1;
        else
            res.value = held_keys.pop_front();
        res.occupancy = OCC_W'(held_keys.size());
        return res;
    endfunction

    // Key mix: full range, extremes, small integers, or a few close values
    function automatic logic [KEY_W-1:0] pick_key(bit narrow);
        if (narrow)
            return KEY_W'($urandom_range(0, 3)) << 16;
        case ($urandom_range(0, 5))
            0: return KEY_W'($urandom_range(0, 16) - 8) << 16;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Queue one op and track the fill level it leads to
    task automatic add_op(logic kind, logic [KEY_W-1:0] key);
        pq_op_t op;
        op.kind = kind;
        op.key = key;
        op.wait_idle = pause_next;
        pause_next = 1'b0;
        pending_ops.push_back(op);
        if (kind == KIND_PUSH)
        begin
            if (gen_count < QUEUE_DEPTH)
                gen_count++;
        end
        else if (gen_count > 0)
            gen_count--;
    endtask

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Source side: offer ops from the pending queue, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= 1'b0;
            tail_phase <= 1'b0;
            src_gap = 0;
            sent_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                awaited_results.push_back(pq_apply_op(cur_op));
                sent_count++;
                if (!tail_phase && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 15);
            end
            if (s_tvalid && !s_tready)
            begin
                // hold the beat until it is taken
            end
            else if (src_gap != 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_ops.size() != 0 &&
                     (!pending_ops[0].wait_idle || sent_count == results_seen))
            begin
                cur_op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= cur_op.key;
                s_tuser <= cur_op.kind;
            end
            else
                s_tvalid <= 1'b0;
            tail_phase <= pending_ops.size() < TAIL_OPS;
        end
    end

    // One long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count <= 0;
            hold_used <= 1'b0;
        end
        else if (!hold_used && results_seen >= LONG_HOLD_AFTER)
        begin
            hold_count <= LONG_HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_count != 0)
            hold_count <= hold_count - 1;
    end

    assign long_hold_active = hold_count != 0;

    // Sink side: check each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            results_seen <= 0;
            sink_stall = 0;
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat tdata=%h tuser=%b",
                                 $realtime, m_tdata, m_tuser);
                end
                else
                begin
                    want_res = awaited_results.pop_front();
                    if (m_tdata[31:0] !== want_res.value ||
                        m_tdata[38:32] !== want_res.occupancy ||
                        m_tdata[39] !== 1'b0 ||
                        m_tuser[0] !== want_res.was_empty ||
                        m_tuser[1] !== want_res.dropped)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result %0d mismatch: value exp %h got %h",
                                     $realtime, results_seen,
                                     want_res.value, m_tdata[31:0]);
                            $display("    occupancy exp %0d got %0d, pad got %b",
                                     want_res.occupancy, m_tdata[38:32], m_tdata[39]);
                            $display("    was_empty exp %b got %b, dropped exp %b got %b",
                                     want_res.was_empty, m_tuser[0],
                                     want_res.dropped, m_tuser[1]);
                        end
                    end
                end
            end
            // Random stall bursts, none in the tail of the run
            if (sink_stall != 0)
            begin
                sink_stall--;
                m_tready <= 1'b0;
            end
            else if (!tail_phase && $urandom_range(0, 9) == 0)
            begin
                sink_stall = $urandom_range(0, 14);
                m_tready <= 1'b0;
            end
            else
                m_tready <= !long_hold_active;
        end
    end

    // Build the op stream, release reset, then wait for the queue to drain
    initial
    begin
        int phase;
        gen_count = 0;
        pause_next = 1'b0;

        // Directed: empty dequeue, key extremes, equal keys, drain past empty
        add_op(KIND_POP, 32'h1234_5678);
        add_op(KIND_PUSH, 32'h7FFF_FFFF);
        add_op(KIND_PUSH, 32'h8000_0000);
        add_op(KIND_PUSH, 32'h0000_0000);
        add_op(KIND_PUSH, 32'hFFFF_FFFF);
        add_op(KIND_PUSH, 32'h0000_0001);
        add_op(KIND_PUSH, 32'h0001_0000);
        add_op(KIND_PUSH, 32'h0001_0000);
        add_op(KIND_PUSH, 32'h0000_8000);
        repeat (9)
            add_op(KIND_POP, 32'hFFFF_FFFF);

        // Random phases: fill past full, drain past empty, mixed, clustered keys
        phase = 0;
        while (pending_ops.size() < DIRECTED_OPS + RANDOM_OPS)
        begin
            if (phase % 5 == 2)
                pause_next = 1'b1;
            case ($urandom_range(0, 3))
                0:
                begin
                    while (gen_count < QUEUE_DEPTH)
                        add_op(($urandom_range(0, 4) == 0) ? KIND_POP : KIND_PUSH,
                               pick_key(1'b0));
                    repeat ($urandom_range(1, 4))
                        add_op(KIND_PUSH, pick_key(1'b0));
                end
                1:
                begin
                    while (gen_count > 0)
                        add_op(($urandom_range(0, 4) == 0) ? KIND_PUSH : KIND_POP,
                               pick_key(1'b0));
                    repeat ($urandom_range(1, 3))
                        add_op(KIND_POP, pick_key(1'b0));
                end
                2:
                begin
                    repeat ($urandom_range(20, 60))
                        add_op(1'($urandom_range(0, 1)), pick_key(1'b0));
                end
                default:
                begin
                    repeat ($urandom_range(20, 40))
                        add_op(($urandom_range(0, 9) < 6) ? KIND_PUSH : KIND_POP,
                               pick_key(1'b1));
                end
            endcase
            phase++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
